// File: src/cross_entropy_loss_mean_assert.svh
// assertion macros for the cross entropy loss block
`ifndef CROSS_ENTROPY_LOSS_MEAN_ASSERT_SVH
`define CROSS_ENTROPY_LOSS_MEAN_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CELM_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication
`define CELM_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define CELM_ASSERT_IMP(label, clk, rst_n, a, b, msg)
`define CELM_ASSERT_NXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// File: src/celm_pkg.sv
`timescale 1ns / 1ps
package celm_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_LABEL_MODE = 2'd0;
    localparam logic [1:0] REG_CLIP_LOW   = 2'd1;
    localparam logic [1:0] REG_CLIP_HIGH  = 2'd2;

    // register reset values
    localparam logic [31:0] CLIP_LOW_RST  = 32'd2147;
    localparam logic [31:0] CLIP_HIGH_RST = 32'd2147481501;

    // arithmetic constants
    localparam logic [31:0] Q31_ONE    = 32'h8000_0000;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam int          FRAC_BITS  = 28;
    localparam int          DIV_BITS   = 49;
    localparam logic [47:0] TOTAL_MAX  = 48'hFFFF_FFFF_FFFF;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic norm_shift;
        logic sqr_step;
        logic mul_lo;
        logic mul_hi;
        logic round;
        logic acc;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic row_end;
        logic batch_end;
        logic conf_zero;
        logic norm_done;
        logic out_free;
    } t_sts;

endpackage

// File: src/celm_dp.sv
`timescale 1ns / 1ps
module celm_dp
    import celm_pkg::*;
#(
    parameter int MAX_CLASSES = 256,
    parameter int MAX_SAMPLES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [31:0] i_pred_prob,
    input  logic [7:0]  i_true_label,
    input  logic        i_target_bit,
    input  logic        i_last_in_row,
    input  logic        i_last_in_batch,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [31:0] o_sample_loss,
    output logic        o_zero_confidence,
    output logic [31:0] o_batch_mean,
    output logic        o_mean_valid,
    output logic [16:0] o_batch_samples
);

    localparam int CCW = $clog2(MAX_CLASSES + 1);
    localparam int SCW = $clog2(MAX_SAMPLES + 1);
    localparam int LW  = (CCW > 8) ? CCW : 8;

    logic             r_label_mode;
    logic [31:0]      r_clip_low, r_clip_high;
    logic [CCW-1:0]   r_col;
    logic [31:0]      r_conf;
    logic [47:0]      r_total;
    logic [SCW-1:0]   r_count;
    logic             r_batch_end, r_zero;
    logic [31:0]      r_m;
    logic [4:0]       r_shift;
    logic [27:0]      r_f;
    logic [45:0]      r_pp_lo;
    logic [46:0]      r_pp_hi;
    logic [31:0]      r_loss;
    logic [48:0]      r_quo;
    logic [SCW:0]     r_rem;
    logic             r_out_valid;
    logic [31:0]      r_out_loss, r_out_mean;
    logic             r_out_zero, r_out_mv;
    logic [16:0]      r_out_samples;

    logic [31:0]      n_clamp, n_conf;
    logic [32:0]      n_sum;
    logic [63:0]      n_prod;
    logic [32:0]      n_sq;
    logic [32:0]      n_l;
    logic [63:0]      n_rnd;
    logic [48:0]      n_tot_sum;
    logic [SCW:0]     n_rem_sh;
    logic [31:0]      n_mean;

    // clamp and row confidence update
    always_comb begin
        if (i_pred_prob < r_clip_low) begin
            n_clamp = r_clip_low;
        end else if (i_pred_prob > r_clip_high) begin
            n_clamp = r_clip_high;
        end else begin
            n_clamp = i_pred_prob;
        end
        n_sum  = 33'(r_conf) + 33'(n_clamp);
        n_conf = r_conf;
        if (r_col < CCW'(MAX_CLASSES)) begin
            if (!r_label_mode) begin
                if (LW'(r_col) == LW'(i_true_label)) begin
                    n_conf = (n_clamp > Q31_ONE) ? Q31_ONE : n_clamp;
                end
            end else if (i_target_bit) begin
                n_conf = (n_sum > 33'(Q31_ONE)) ? Q31_ONE : n_sum[31:0];
            end
        end
    end

    // log and division arithmetic
    always_comb begin
        n_prod    = 64'(r_m) * 64'(r_m);
        n_sq      = n_prod[63:31];
        n_l       = (33'(r_shift) << FRAC_BITS) - 33'(r_f);
        n_rnd     = (64'(r_pp_hi) << 16) + 64'(r_pp_lo) + (64'(1) << 33);
        n_tot_sum = 49'(r_total) + 49'(r_loss);
        n_rem_sh  = {r_rem[SCW-1:0], r_quo[48]};
        n_mean    = (r_quo[48:32] != 17'd0) ? 32'hFFFF_FFFF : r_quo[31:0];
    end

    assign o_sts.row_end   = i_last_in_row | i_last_in_batch;
    assign o_sts.batch_end = r_batch_end;
    assign o_sts.conf_zero = r_zero;
    assign o_sts.norm_done = r_m[31];
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_mode <= 1'b0;
            r_clip_low   <= CLIP_LOW_RST;
            r_clip_high  <= CLIP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LABEL_MODE: r_label_mode <= i_cfg_data[0];
                REG_CLIP_LOW:   r_clip_low   <= i_cfg_data;
                REG_CLIP_HIGH:  r_clip_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // row and batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_conf      <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (o_sts.row_end) begin
                    r_col  <= '0;
                    r_conf <= '0;
                end else begin
                    r_conf <= n_conf;
                    if (r_col < CCW'(MAX_CLASSES)) begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end
            if (i_cmd.acc && (r_count < SCW'(MAX_SAMPLES))) begin
                r_count <= r_count + 1'b1;
                r_total <= n_tot_sum[48] ? TOTAL_MAX : n_tot_sum[47:0];
            end
            if (i_cmd.out_load && r_batch_end) begin
                r_total <= '0;
                r_count <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // row-end arithmetic and output registers: normalize, square, scale, divide, load
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_m         <= n_conf;
            r_zero      <= (n_conf == 32'd0);
            r_batch_end <= i_last_in_batch;
            r_shift     <= '0;
            r_f         <= '0;
            r_loss      <= 32'hFFFF_FFFF;
        end
        if (i_cmd.norm_shift) begin
            r_m     <= r_m << 1;
            r_shift <= r_shift + 1'b1;
        end
        if (i_cmd.sqr_step) begin
            r_m <= n_sq[32] ? n_sq[32:1] : n_sq[31:0];
            r_f <= {r_f[26:0], n_sq[32]};
        end
        if (i_cmd.mul_lo) begin
            r_pp_lo <= 46'(n_l[15:0]) * 46'(LN2_Q30);
        end
        if (i_cmd.mul_hi) begin
            r_pp_hi <= 47'(n_l[32:16]) * 47'(LN2_Q30);
        end
        if (i_cmd.round) begin
            r_loss <= 32'(n_rnd[63:34]);
        end
        if (i_cmd.div_init) begin
            r_quo <= 49'(r_total) + 49'(r_count >> 1);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            if (n_rem_sh >= (SCW+1)'(r_count)) begin
                r_rem <= n_rem_sh - (SCW+1)'(r_count);
                r_quo <= {r_quo[47:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh;
                r_quo <= {r_quo[47:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out_loss    <= r_loss;
            r_out_zero    <= r_zero;
            r_out_mv      <= r_batch_end;
            r_out_mean    <= r_batch_end ? n_mean : 32'd0;
            r_out_samples <= 17'(r_count);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample_loss     = r_out_loss;
    assign o_zero_confidence = r_out_zero;
    assign o_batch_mean      = r_out_mean;
    assign o_mean_valid      = r_out_mv;
    assign o_batch_samples   = r_out_samples;

endmodule

// File: src/celm_ctrl.sv
`timescale 1ns / 1ps
module celm_ctrl
    import celm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_NORM  = 10'b00_0000_0010,
        S_SQR   = 10'b00_0000_0100,
        S_MULLO = 10'b00_0000_1000,
        S_MULHI = 10'b00_0001_0000,
        S_RND   = 10'b00_0010_0000,
        S_ACC   = 10'b00_0100_0000,
        S_DINIT = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_iter, n_iter;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_iter     = r_iter;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.row_end) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_iter = '0;
                if (i_sts.conf_zero) begin
                    n_state = S_ACC;
                end else if (i_sts.norm_done) begin
                    n_state = S_SQR;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            S_SQR: begin
                o_cmd.sqr_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == 6'(FRAC_BITS - 1)) begin
                    n_state = S_MULLO;
                end
            end
            S_MULLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.round = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_sts.batch_end ? S_DINIT : S_OUT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_iter  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == 6'(DIV_BITS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

// File: src/cross_entropy_loss_mean.sv
`timescale 1ns / 1ps
// channel   direction  handshake                   word
// input     in         i_in_valid / o_in_ready     pred_prob, true_label, target_bit, last flags
// result    out        o_out_valid / i_out_ready   sample_loss, zero_confidence, mean, samples
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// an element that does not end a row is accepted while the sequencer stays idle
// a row end on zero confidence goes straight to sum and output load; else it runs normalize,
// 28 squarings, three scaling steps, sum, output load
// a batch end adds the bit-serial mean divider ahead of the output load
// synchronous active-low reset clears config, row and batch state, output valid
// a stalled result holds in the output register; the next element is taken meanwhile
module cross_entropy_loss_mean
    import celm_pkg::*;
#(
    parameter int MAX_CLASSES = 256,
    parameter int MAX_SAMPLES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pred_prob,
    input  logic [7:0]  i_true_label,
    input  logic        i_target_bit,
    input  logic        i_last_in_row,
    input  logic        i_last_in_batch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sample_loss,
    output logic        o_zero_confidence,
    output logic [31:0] o_batch_mean,
    output logic        o_mean_valid,
    output logic [16:0] o_batch_samples,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

`include "cross_entropy_loss_mean_assert.svh"

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    celm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    celm_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pred_prob       (i_pred_prob),
        .i_true_label      (i_true_label),
        .i_target_bit      (i_target_bit),
        .i_last_in_row     (i_last_in_row),
        .i_last_in_batch   (i_last_in_batch),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_sample_loss     (o_sample_loss),
        .o_zero_confidence (o_zero_confidence),
        .o_batch_mean      (o_batch_mean),
        .o_mean_valid      (o_mean_valid),
        .o_batch_samples   (o_batch_samples)
    );

    // checks
    `CELM_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_cmd.out_load, (!o_out_valid || i_out_ready), "result overwritten")
    `CELM_ASSERT_IMP(a_mean_zero, i_clk, i_rst_n, (o_out_valid && !o_mean_valid), (o_batch_mean == 32'd0), "mean without flag")
    `CELM_ASSERT_IMP(a_zero_sat, i_clk, i_rst_n, (o_out_valid && o_zero_confidence), (o_sample_loss == 32'hFFFF_FFFF), "zero confidence loss not saturated")
    `CELM_ASSERT_NXT(a_load_valid, i_clk, i_rst_n, w_cmd.out_load, o_out_valid, "loaded result not shown")

endmodule
